// ===== hdl/rc_pkg.sv =====
// Package for the RC5/RC6 block cipher unit: payload structs, register
// indexes, constants and rotate helpers. No dependencies.
package rc_pkg;

  localparam int unsigned MaxRounds   = 24;
  localparam int unsigned TableDepth  = 2 * MaxRounds + 4;
  localparam int unsigned TabAw       = $clog2(TableDepth);
  localparam int unsigned KeyWords    = 8;
  localparam int unsigned KwAw        = 3;
  localparam int unsigned CfgAw       = 3;
  localparam int unsigned CfgDw       = 64;

  localparam logic [31:0] RcP32 = 32'hb7e15163;
  localparam logic [31:0] RcQ32 = 32'h9e3779b9;

  localparam logic [CfgAw-1:0] RegMode   = 3'd0;
  localparam logic [CfgAw-1:0] RegRounds = 3'd1;
  localparam logic [CfgAw-1:0] RegKeyLen = 3'd2;
  localparam logic [CfgAw-1:0] RegKey0   = 3'd3;
  localparam logic [CfgAw-1:0] RegKey1   = 3'd4;
  localparam logic [CfgAw-1:0] RegKey2   = 3'd5;
  localparam logic [CfgAw-1:0] RegKey3   = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } rc_in_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [31:0] out_d;
  } rc_out_t;

  typedef enum logic [3:0] {
    StIdle, StSeed, StMixRd, StMixA, StMixB,
    StPre0, StPre1, StPre2, StRndRd, StRnd0, StRnd1, StPost, StDone
  } rc_state_e;

  function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(logic [31:0] x, logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

endpackage

// ===== hdl/rc_ram.sv =====
// Generic one-write, one-read synchronous RAM with registered read data.
// No dependencies.
module rc_ram #(
  parameter int unsigned Depth = 52,
  parameter int unsigned Aw    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/rc5_rc6_block_cipher_unit.sv =====
// Top level of the RC5/RC6 cipher unit: config registers, key schedule
// sequencer and round datapath over subkey and key-word RAMs. Uses rc_pkg, rc_ram.
//
// One word (block) is accepted at a time. After reset or any config write to
// RegMode through RegKey3, the first word runs the key schedule before the
// block. The schedule seeds max(nsub, 8) table entries, passes a read state
// and then runs 3 * max(nsub, nkw) mixing steps (nsub = 2r+2 or 2r+4). Each
// round reads its two subkeys in turn, in states StRndRd, StRnd0 and StRnd1,
// through the single read port of the subkey RAM. The RC6 quadratic function
// needs two 32x32 multiplies per round, registered. The result sits in an
// output register while the next word may be accepted.
// A block that finishes while the previous result still waits holds until
// that result leaves.
module rc5_rc6_block_cipher_unit
  import rc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgAw-1:0]  cfg_idx_i,
  input  logic [CfgDw-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rc_in_t            in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rc_out_t           out_data_o
);
  // config registers
  logic        mode_q;
  logic [4:0]  rounds_q;
  logic [5:0]  klen_q;
  logic [63:0] key_q [4];
  logic        sched_ok_q;
  logic        sched_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      rounds_q   <= 5'd20;
      klen_q     <= 6'd16;
      key_q[0]   <= '0;
      key_q[1]   <= '0;
      key_q[2]   <= '0;
      key_q[3]   <= '0;
      sched_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode:   mode_q   <= cfg_data_i[0];
          RegRounds: rounds_q <= cfg_data_i[4:0];
          RegKeyLen: klen_q   <= cfg_data_i[5:0];
          RegKey0:   key_q[0] <= cfg_data_i;
          RegKey1:   key_q[1] <= cfg_data_i;
          RegKey2:   key_q[2] <= cfg_data_i;
          RegKey3:   key_q[3] <= cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i <= RegKey3) sched_ok_q <= 1'b0;
      end else if (sched_set) begin
        sched_ok_q <= 1'b1;
      end
    end
  end

  // effective rounds and table sizes
  logic [4:0] eff_r;
  logic [5:0] nsub, nkw, klen_c, seed_end;
  always_comb begin
    if (rounds_q == 5'd0) eff_r = 5'd20;
    else if (rounds_q >= 5'd25) eff_r = rounds_q - 5'd25;
    else eff_r = rounds_q;
    nsub   = {eff_r, 1'b0} + (mode_q ? 6'd4 : 6'd2);
    klen_c = (klen_q > 6'd32) ? 6'd32 : klen_q;
    nkw    = (klen_c == 6'd0) ? 6'd1 : 6'((klen_c + 6'd3) >> 2);
    seed_end = (nsub > 6'(KeyWords)) ? nsub : 6'(KeyWords);
  end

  // packed key word from config bytes, masked by key length
  logic [KwAw-1:0] kw_sel;
  logic [31:0]     kw_init;
  always_comb begin
    logic [63:0] src;
    logic [5:0]  base;
    src = key_q[kw_sel[2:1]];
    kw_init = kw_sel[0] ? src[63:32] : src[31:0];
    base = {1'b0, kw_sel, 2'b00};
    for (int k = 0; k < 4; k++) begin
      if (base + 6'(k) >= klen_c) kw_init[k*8 +: 8] = 8'h00;
    end
  end

  // RAMs
  logic              sk_we;
  logic [TabAw-1:0]  sk_wa, sk_ra;
  logic [31:0]       sk_wd, sk_rd;
  logic              kw_we;
  logic [KwAw-1:0]   kw_wa, kw_ra;
  logic [31:0]       kw_wd, kw_rd;

  rc_ram #(.Depth(TableDepth), .Aw(TabAw)) u_sk_ram (
    .clk_i, .we_i(sk_we), .waddr_i(sk_wa), .wdata_i(sk_wd),
    .raddr_i(sk_ra), .rdata_o(sk_rd)
  );
  rc_ram #(.Depth(KeyWords), .Aw(KwAw)) u_kw_ram (
    .clk_i, .we_i(kw_we), .waddr_i(kw_wa), .wdata_i(kw_wd),
    .raddr_i(kw_ra), .rdata_o(kw_rd)
  );

  // sequencer registers
  rc_state_e        st_q, st_d;
  logic [TabAw-1:0] i_q, i_d;
  logic [KwAw-1:0]  j_q, j_d;
  logic [7:0]       n_q, n_d;
  logic [31:0]      a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [31:0]      ma_q, ma_d, mb_q, mb_d, seed_q, seed_d;
  logic [31:0]      t_q, t_d, u_q, u_d, k0_q, k0_d;
  logic [4:0]       rnd_q, rnd_d;
  logic             dec_q, dec_d;
  logic             ov_q, ov_d;
  rc_out_t          res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; n_q <= n_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    ma_q <= ma_d; mb_q <= mb_d; seed_q <= seed_d;
    t_q <= t_d; u_q <= u_d; k0_q <= k0_d;
    rnd_q <= rnd_d; dec_q <= dec_d; res_q <= res_d;
  end

  assign in_ready_o  = (st_q == StIdle) && !cfg_we_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  // RC6 quadratic f(x) = rotl(x*(2x+1), 5)
  function automatic logic [31:0] f6(logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rotl32(p, 5'd5);
  endfunction

  logic [7:0] loops;
  assign loops = (nsub > nkw) ? 8'(nsub) * 8'd3 : 8'(nkw) * 8'd3;

  logic [TabAw-1:0] sub_hi;
  assign sub_hi = TabAw'({eff_r, 1'b0} + 6'd2);

  // control and datapath
  always_comb begin
    logic [31:0] sum, na, nb, x, y;
    st_d = st_q; i_d = i_q; j_d = j_q; n_d = n_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    ma_d = ma_q; mb_d = mb_q; seed_d = seed_q;
    t_d = t_q; u_d = u_q; k0_d = k0_q;
    rnd_d = rnd_q; dec_d = dec_q; res_d = res_q;
    ov_d = ov_q && !out_ready_i;
    sched_set = 1'b0;
    sk_we = 1'b0; sk_wa = i_q; sk_wd = '0; sk_ra = i_q;
    kw_we = 1'b0; kw_wa = j_q; kw_wd = '0; kw_ra = j_q;
    kw_sel = j_q;
    sum = '0; na = '0; nb = '0; x = '0; y = '0;

    unique case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          dec_d = in_data_i.cmd;
          a_d = in_data_i.word_a; b_d = in_data_i.word_b;
          c_d = in_data_i.word_c; d_d = in_data_i.word_d;
          i_d = '0; j_d = '0; seed_d = RcP32;
          st_d = sched_ok_q ? StPre0 : StSeed;
        end
      end
      // seed subkeys and load every key word
      StSeed: begin
        sk_we = 1'b1; sk_wa = i_q; sk_wd = seed_q;
        seed_d = seed_q + RcQ32;
        kw_we = 1'b1; kw_wa = j_q; kw_wd = kw_init;
        j_d = j_q + KwAw'(1);
        if (6'(i_q) + 6'd1 == seed_end) begin
          i_d = '0; j_d = '0; n_d = '0; ma_d = '0; mb_d = '0;
          st_d = StMixRd;
        end else begin
          i_d = i_q + TabAw'(1);
        end
      end
      StMixRd: st_d = StMixA;
      // S[i] = rotl(S[i] + A + B, 3)
      StMixA: begin
        na = rotl32(sk_rd + ma_q + mb_q, 5'd3);
        sk_we = 1'b1; sk_wa = i_q; sk_wd = na;
        ma_d = na;
        st_d = StMixB;
      end
      // L[j] = rotl(L[j] + A + B, A + B)
      StMixB: begin
        sum = ma_q + mb_q;
        nb = rotl32(kw_rd + sum, sum[4:0]);
        kw_we = 1'b1; kw_wa = j_q; kw_wd = nb;
        mb_d = nb;
        i_d = (6'(i_q) + 6'd1 == nsub) ? '0 : i_q + TabAw'(1);
        j_d = (6'(j_q) + 6'd1 == nkw) ? '0 : j_q + KwAw'(1);
        n_d = n_q + 8'd1;
        sk_ra = i_d; kw_ra = j_d;
        if (n_q + 8'd1 == loops) begin
          sched_set = 1'b1;
          st_d = StPre0;
        end else begin
          st_d = StMixA;
        end
      end
      // read pre-whitening subkeys (decrypt RC6 uses post keys first)
      StPre0: begin
        sk_ra = (mode_q && dec_q) ? sub_hi : (dec_q ? TabAw'(2) : '0);
        if (mode_q && dec_q) sk_ra = sub_hi;
        else if (dec_q) sk_ra = sub_hi - TabAw'(1) - (mode_q ? TabAw'(0) : TabAw'(1));
        else sk_ra = '0;
        st_d = StPre1;
        rnd_d = dec_q ? eff_r : 5'd1;
      end
      StPre1: begin
        k0_d = sk_rd;
        if (mode_q && dec_q) sk_ra = sub_hi + TabAw'(1);
        else if (dec_q) sk_ra = sub_hi - TabAw'(1);
        else sk_ra = TabAw'(1);
        st_d = StPre2;
      end
      StPre2: begin
        if (mode_q && dec_q) begin
          a_d = a_q - k0_q; c_d = c_q - sk_rd;
        end else if (!dec_q) begin
          if (mode_q) begin
            b_d = b_q + k0_q; d_d = d_q + sk_rd;
          end else begin
            a_d = a_q + k0_q; b_d = b_q + sk_rd;
          end
        end
        st_d = (eff_r == 5'd0) ? StPost : StRndRd;
        i_d = TabAw'({rnd_d, 1'b0});
        if (dec_q && !mode_q) st_d = StRndRd;
        if (dec_q && !mode_q && eff_r == 5'd0) st_d = StPost;
      end
      // per round: read S[2i], then S[2i+1]
      StRndRd: begin
        sk_ra = TabAw'({rnd_q, 1'b0});
        if (mode_q) begin
          if (dec_q) begin
            a_d = d_q; b_d = a_q; c_d = b_q; d_d = c_q;
            t_d = f6(a_q); u_d = f6(c_q);
          end else begin
            t_d = f6(b_q); u_d = f6(d_q);
          end
        end
        st_d = StRnd0;
      end
      StRnd0: begin
        k0_d = sk_rd;
        sk_ra = TabAw'({rnd_q, 1'b1});
        st_d = StRnd1;
      end
      StRnd1: begin
        if (!mode_q) begin
          if (!dec_q) begin
            na = rotl32(a_q ^ b_q, b_q[4:0]) + k0_q;
            nb = rotl32(b_q ^ na, na[4:0]) + sk_rd;
            a_d = na; b_d = nb;
          end else begin
            nb = rotr32(b_q - sk_rd, a_q[4:0]) ^ a_q;
            na = rotr32(a_q - k0_q, nb[4:0]) ^ nb;
            a_d = na; b_d = nb;
          end
        end else begin
          if (!dec_q) begin
            x = rotl32(a_q ^ t_q, u_q[4:0]) + k0_q;
            y = rotl32(c_q ^ u_q, t_q[4:0]) + sk_rd;
            a_d = b_q; b_d = y; c_d = d_q; d_d = x;
          end else begin
            c_d = rotr32(c_q - sk_rd, t_q[4:0]) ^ u_q;
            a_d = rotr32(a_q - k0_q, u_q[4:0]) ^ t_q;
          end
        end
        if ((dec_q && rnd_q == 5'd1) || (!dec_q && rnd_q == eff_r)) begin
          st_d = StPost;
          rnd_d = rnd_q;
        end else begin
          rnd_d = dec_q ? rnd_q - 5'd1 : rnd_q + 5'd1;
          st_d = StRndRd;
        end
      end
      // post-whitening: read two subkeys
      StPost: begin
        if (dec_q) sk_ra = '0;
        else sk_ra = mode_q ? sub_hi : '0;
        if (!dec_q && !mode_q) st_d = StDone;
        else begin
          st_d = StDone;
          n_d = 8'd0;
        end
        rnd_d = 5'd0;
      end
      StDone: begin
        // two-step finish: first capture one key, then the other (RC5 encrypt ends in the first)
        if (rnd_q == 5'd0) begin
          k0_d = sk_rd;
          sk_ra = (dec_q || !mode_q) ? TabAw'(1) : sub_hi + TabAw'(1);
          rnd_d = 5'd1;
          if (!dec_q && !mode_q) begin
            res_d = {a_q, b_q, c_q, d_q};
            ov_d = 1'b1;
            st_d = StIdle;
          end
        end else begin
          // keep the second key on the read port while the output stalls
          sk_ra = (dec_q || !mode_q) ? TabAw'(1) : sub_hi + TabAw'(1);
          if (!ov_q || out_ready_i) begin
            if (mode_q && !dec_q) begin
              res_d = {a_q + k0_q, b_q, c_q + sk_rd, d_q};
            end else if (mode_q) begin
              res_d = {a_q, b_q - k0_q, c_q, d_q - sk_rd};
            end else begin
              res_d = {a_q - k0_q, b_q - sk_rd, c_q, d_q};
            end
            ov_d = 1'b1;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
    if (st_q == StDone && rnd_q == 5'd0 && !dec_q && !mode_q && ov_q && !out_ready_i) begin
      st_d = StDone; ov_d = 1'b1; res_d = res_q; rnd_d = 5'd0;
    end
  end
endmodule

// ===== verif/rc5_rc6_block_cipher_unit_scoreboard.sv =====
// Checker for the RC5/RC6 cipher unit: mirrors the config registers, predicts
// each block result with its own key schedule and compares. Uses rc_pkg.
`timescale 1ns / 1ps

module rc5_rc6_block_cipher_unit_scoreboard
  import rc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_idx_i,
  input  logic [CfgDw-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  rc_in_t           in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  rc_out_t          out_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Mirrored configuration and schedule state
  logic        mode_q;
  logic [4:0]  rounds_q;
  logic [5:0]  keylen_q;
  logic [63:0] key_q [4];
  logic [31:0] subkeys [TableDepth];
  logic [31:0] key_words [KeyWords];
  logic        schedule_ok;

  rc_out_t expected_words [$];

  function automatic logic [31:0] rot_left(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x << s) | (x >> (6'd32 - s));
  endfunction

  function automatic logic [31:0] rot_right(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x >> s) | (x << (6'd32 - s));
  endfunction

  function automatic int unsigned active_rounds();
    int unsigned r;
    r = (rounds_q == 5'd0) ? 20 : (rounds_q % 25);
    if (r > MaxRounds) r = MaxRounds;
    return r;
  endfunction

  function automatic logic [31:0] quad_mix(logic [31:0] x);
    logic [31:0] p;
    p = x * ((x << 1) + 32'd1);
    return rot_left(p, 32'd5);
  endfunction

  // Rebuild the subkey table from the mirrored key registers
  task automatic build_schedule();
    int unsigned r, nsub, len, nkw, loops, i, j, n;
    logic [31:0] a, b;
    logic [7:0]  kb;
    r = active_rounds();
    nsub = mode_q ? 2 * r + 4 : 2 * r + 2;
    len = (keylen_q > 32) ? 32 : keylen_q;
    nkw = (len + 3) / 4;
    if (nkw == 0) nkw = 1;
    for (i = 0; i < KeyWords; i++) key_words[i] = '0;
    for (i = 0; i < len; i++) begin
      kb = key_q[i >> 3][(i & 7) * 8 +: 8];
      key_words[i >> 2] |= 32'(kb) << ((i & 3) * 8);
    end
    subkeys[0] = RcP32;
    for (i = 1; i < nsub; i++) subkeys[i] = subkeys[i - 1] + RcQ32;
    loops = 3 * ((nsub > nkw) ? nsub : nkw);
    a = '0; b = '0; i = 0; j = 0;
    for (n = 0; n < loops; n++) begin
      subkeys[i] = rot_left(subkeys[i] + a + b, 32'd3);
      a = subkeys[i];
      key_words[j] = rot_left(key_words[j] + a + b, a + b);
      b = key_words[j];
      i = (i + 1 == nsub) ? 0 : i + 1;
      j = (j + 1 == nkw) ? 0 : j + 1;
    end
    schedule_ok = 1'b1;
  endtask

  task automatic predict_block(input rc_in_t w, output rc_out_t res);
    logic [31:0] a, b, c, d, t, u, s;
    int r, i;
    if (!schedule_ok) build_schedule();
    r = active_rounds();
    a = w.word_a; b = w.word_b; c = w.word_c; d = w.word_d;
    if (!mode_q) begin
      if (!w.cmd) begin
        a += subkeys[0];
        b += subkeys[1];
        for (i = 1; i <= r; i++) begin
          a = rot_left(a ^ b, b) + subkeys[2 * i];
          b = rot_left(b ^ a, a) + subkeys[2 * i + 1];
        end
      end else begin
        for (i = r; i >= 1; i--) begin
          b = rot_right(b - subkeys[2 * i + 1], a) ^ a;
          a = rot_right(a - subkeys[2 * i], b) ^ b;
        end
        a -= subkeys[0];
        b -= subkeys[1];
      end
    end else begin
      if (!w.cmd) begin
        b += subkeys[0];
        d += subkeys[1];
        for (i = 1; i <= r; i++) begin
          t = quad_mix(b);
          u = quad_mix(d);
          a = rot_left(a ^ t, u) + subkeys[2 * i];
          c = rot_left(c ^ u, t) + subkeys[2 * i + 1];
          s = a; a = b; b = c; c = d; d = s;
        end
        a += subkeys[2 * r + 2];
        c += subkeys[2 * r + 3];
      end else begin
        c -= subkeys[2 * r + 3];
        a -= subkeys[2 * r + 2];
        for (i = r; i >= 1; i--) begin
          s = d; d = c; c = b; b = a; a = s;
          u = quad_mix(d);
          t = quad_mix(b);
          c = rot_right(c - subkeys[2 * i + 1], t) ^ u;
          a = rot_right(a - subkeys[2 * i], u) ^ t;
        end
        d -= subkeys[1];
        b -= subkeys[0];
      end
    end
    res.out_a = a; res.out_b = b; res.out_c = c; res.out_d = d;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_words.size();

  // Track config writes, predict accepted words, compare delivered words
  always @(posedge clk_i or negedge rst_ni) begin
    rc_out_t pred, exp_w;
    if (!rst_ni) begin
      mode_q <= 1'b0;
      rounds_q <= 5'd20;
      keylen_q <= 6'd16;
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      schedule_ok <= 1'b0;
      fail_count_o <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMode:   begin mode_q = cfg_data_i[0];     schedule_ok = 1'b0; end
          RegRounds: begin rounds_q = cfg_data_i[4:0]; schedule_ok = 1'b0; end
          RegKeyLen: begin keylen_q = cfg_data_i[5:0]; schedule_ok = 1'b0; end
          RegKey0:   begin key_q[0] = cfg_data_i;      schedule_ok = 1'b0; end
          RegKey1:   begin key_q[1] = cfg_data_i;      schedule_ok = 1'b0; end
          RegKey2:   begin key_q[2] = cfg_data_i;      schedule_ok = 1'b0; end
          RegKey3:   begin key_q[3] = cfg_data_i;      schedule_ok = 1'b0; end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_block(in_data_i, pred);
        expected_words.push_back(pred);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("out_a", exp_w.out_a, out_data_i.out_a);
          check_field("out_b", exp_w.out_b, out_data_i.out_b);
          check_field("out_c", exp_w.out_c, out_data_i.out_c);
          check_field("out_d", exp_w.out_d, out_data_i.out_d);
        end
      end
    end
  end

endmodule

// ===== verif/rc5_rc6_block_cipher_unit_test.sv =====
// Testbench top for the RC5/RC6 cipher unit: clock, reset, config phases,
// bursty block stimulus and output stalls. Uses rc_pkg and the scoreboard.
`timescale 1ns / 1ps

module rc5_rc6_block_cipher_unit_test;
  import rc_pkg::*;

  localparam logic [CfgAw-1:0] RegSpare = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgAw-1:0] cfg_idx_i;
  logic [CfgDw-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  rc_in_t           in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  rc_out_t          out_data_o;
  int               fail_count;
  int               pending;
  int               burst_left;

  rc5_rc6_block_cipher_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  rc5_rc6_block_cipher_unit_scoreboard i_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output side on a pattern chosen at random from four modes
  initial begin
    int stall_mode;
    out_ready_i <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      repeat (64) begin
        @(posedge clk_i);
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= $urandom_range(0, 1);
          2: out_ready_i <= ($urandom_range(0, 7) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #5ms;
    $display("rc5_rc6_block_cipher_unit_test failed");
    $finish;
  end

  // Drive one word, with bursts and random gaps between them
  task automatic send_word(rc_in_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 1)) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_block(logic cmd, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c, logic [31:0] d);
    rc_in_t w;
    w.cmd = cmd; w.word_a = a; w.word_b = b; w.word_c = c; w.word_d = d;
    send_word(w);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Drain the unit, then let it settle before touching config
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAw-1:0] idx, logic [CfgDw-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic mode, logic [4:0] rounds, logic [5:0] keylen,
                            logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3);
    write_reg(RegMode, {$urandom, $urandom} & ~64'h1 | 64'(mode));
    write_reg(RegRounds, 64'(rounds));
    write_reg(RegKeyLen, 64'(keylen));
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_pair();
    send_block(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_block($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [4:0] rounds;
    logic [5:0] keylen;
    int n_items;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    burst_left = 0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then round and key-length extremes
    directed_pair();
    wait_idle();
    set_config(1'b1, 5'd1, 6'd0, '0, '0, '0, '0);
    directed_pair();
    wait_idle();
    set_config(1'b1, 5'd24, 6'd32, '1, '1, '1, '1);
    directed_pair();
    wait_idle();
    set_config(1'b0, 5'd25, 6'd63, {$urandom, $urandom}, '1, '0, '1);
    directed_pair();
    wait_idle();
    set_config(1'b0, 5'd0, 6'd1, {$urandom, $urandom}, '0, '0, '0);
    directed_pair();
    wait_idle();
    set_config(1'b1, 5'd31, 6'd33, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    directed_pair();
    wait_idle();
    // Out-of-range index must leave the schedule alone
    write_reg(RegSpare, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    directed_pair();
    wait_idle();

    // Random phases: new settings, or none to keep the schedule in use
    repeat (12) begin
      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 5))
          0: rounds = 5'd0;
          1: rounds = 5'd1;
          2: rounds = 5'd24;
          3: rounds = 5'($urandom_range(25, 31));
          default: rounds = 5'($urandom_range(1, 12));
        endcase
        keylen = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                             : 6'($urandom_range(0, 32));
        if ($urandom_range(0, 3) == 0) begin
          write_reg(RegSpare, {$urandom, $urandom});
        end
        set_config($urandom_range(0, 1), rounds, keylen,
                   {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
      end
      n_items = $urandom_range(35, 55);
      repeat (n_items) begin
        send_block($urandom_range(0, 1), rand_word(), rand_word(), rand_word(),
                   rand_word());
      end
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rc5_rc6_block_cipher_unit_test passed");
    end else begin
      $display("rc5_rc6_block_cipher_unit_test failed");
    end
    $finish;
  end

endmodule
